@@ hdl/cpmt_pkg.sv @@
// Shared types and constants for the coordinate pair merge table.
package cpmt_pkg;

    // Fixed field widths of the stream and register interfaces.
    localparam int VALUE_W  = 12;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;
    localparam int REG_IDX_W = 2;

    localparam logic [VALUE_W-1:0] RADIUS_RESET = 12'd10;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_MERGE_MODE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SEP    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS     = 2'd2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        MODE_MAX     = 2'd0,
        MODE_MIN     = 2'd1,
        MODE_REPLACE = 2'd2,
        MODE_MIN_MAX = 2'd3
    } t_merge_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_REJECTED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_APPENDED = 3'd2,
        ST_FULL     = 3'd3,
        ST_CLEARED  = 3'd4,
        ST_READ     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FINISH,
        S_READ,
        S_RESULT
    } t_state;

    // Operations the controller asks of the datapath.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ_RESULT,
        OP_REJECT,
        OP_SCAN_START,
        OP_SCAN,
        OP_FINISH
    } t_dp_op;

    // Status the datapath reports to the controller.
    typedef struct packed {
        t_command in_cmd;
        logic     sep_reject;
        logic     table_empty;
        logic     scan_last;
    } t_dp_stat;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   count;
        logic [VALUE_W-1:0]   first;
        logic [VALUE_W-1:0]   second;
    } t_result;

    function automatic logic [VALUE_W-1:0] abs_diff(
        input logic [VALUE_W-1:0] x,
        input logic [VALUE_W-1:0] y
    );
        return (x >= y) ? (x - y) : (y - x);
    endfunction

    function automatic logic [VALUE_W-1:0] max_v(
        input logic [VALUE_W-1:0] x,
        input logic [VALUE_W-1:0] y
    );
        return (x > y) ? x : y;
    endfunction

    function automatic logic [VALUE_W-1:0] min_v(
        input logic [VALUE_W-1:0] x,
        input logic [VALUE_W-1:0] y
    );
        return (x < y) ? x : y;
    endfunction

endpackage

@@ hdl/cpmt_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
module cpmt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic                i_out_free,
    output logic                o_out_load,
    input  cpmt_pkg::t_dp_stat  i_stat,
    output cpmt_pkg::t_dp_op    o_op
);

    cpmt_pkg::t_state r_state;
    cpmt_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_op       = cpmt_pkg::OP_NONE;
        o_s_tready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            cpmt_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_op = cpmt_pkg::OP_LOAD;
                    case (i_stat.in_cmd)
                        cpmt_pkg::CMD_INSERT: n_state = cpmt_pkg::S_CHECK;
                        cpmt_pkg::CMD_CLEAR:  n_state = cpmt_pkg::S_RESULT;
                        cpmt_pkg::CMD_READ:   n_state = cpmt_pkg::S_READ;
                        default:              n_state = cpmt_pkg::S_IDLE;
                    endcase
                end
            end
            cpmt_pkg::S_READ: begin
                o_op    = cpmt_pkg::OP_READ_RESULT;
                n_state = cpmt_pkg::S_RESULT;
            end
            cpmt_pkg::S_CHECK: begin
                if (i_stat.sep_reject) begin
                    o_op    = cpmt_pkg::OP_REJECT;
                    n_state = cpmt_pkg::S_RESULT;
                end else if (i_stat.table_empty) begin
                    n_state = cpmt_pkg::S_FINISH;
                end else begin
                    o_op    = cpmt_pkg::OP_SCAN_START;
                    n_state = cpmt_pkg::S_SCAN;
                end
            end
            cpmt_pkg::S_SCAN: begin
                o_op = cpmt_pkg::OP_SCAN;
                if (i_stat.scan_last) begin
                    n_state = cpmt_pkg::S_FINISH;
                end
            end
            cpmt_pkg::S_FINISH: begin
                o_op    = cpmt_pkg::OP_FINISH;
                n_state = cpmt_pkg::S_RESULT;
            end
            cpmt_pkg::S_RESULT: begin
                // Hand the result over once the output register can take it.
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = cpmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cpmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/cpmt_datapath.sv @@
// Datapath: request registers, the pair table memory, the entry count and merge logic.
module cpmt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cpmt_pkg::t_dp_op                    i_op,
    output cpmt_pkg::t_dp_stat                  o_stat,
    input  cpmt_pkg::t_command                  i_command,
    input  logic [cpmt_pkg::VALUE_W-1:0]        i_first_value,
    input  logic [cpmt_pkg::VALUE_W-1:0]        i_second_value,
    input  logic [cpmt_pkg::INDEX_W-1:0]        i_entry_index,
    input  cpmt_pkg::t_merge_mode               i_merge_mode,
    input  logic [cpmt_pkg::VALUE_W-1:0]        i_min_sep,
    input  logic [cpmt_pkg::VALUE_W-1:0]        i_radius,
    output cpmt_pkg::t_result                   o_result
);

    localparam int VW   = cpmt_pkg::VALUE_W;
    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > cpmt_pkg::INDEX_W) ? CW : cpmt_pkg::INDEX_W;

    // Pair table: second value in the upper half, first value in the lower half.
    logic [2*VW-1:0] mem [TABLE_DEPTH];
    logic [2*VW-1:0] r_rd_data;

    logic [VW-1:0]                   r_first;
    logic [VW-1:0]                   r_second;
    logic [cpmt_pkg::INDEX_W-1:0]    r_index;
    logic [CW-1:0]                   r_count;
    logic [IW-1:0]                   r_scan_idx;
    logic                            r_matched;
    cpmt_pkg::t_status               r_status;
    logic [VW-1:0]                   r_read_first;
    logic [VW-1:0]                   r_read_second;

    logic [IW-1:0]   rd_addr;
    logic [IW-1:0]   wr_addr;
    logic [2*VW-1:0] wr_data;
    logic            wr_en;
    logic [VW-1:0]   ent_first;
    logic [VW-1:0]   ent_second;
    logic [VW-1:0]   mrg_first;
    logic [VW-1:0]   mrg_second;
    logic            match;
    logic            has_room;
    logic            read_hit;

    assign ent_first  = r_rd_data[VW-1:0];
    assign ent_second = r_rd_data[2*VW-1:VW];
    assign has_room   = (r_count < CW'(TABLE_DEPTH));
    assign read_hit   = (CMPW'(r_index) < CMPW'(r_count));

    // Entry under scan lies within the radius on both values.
    assign match = (cpmt_pkg::abs_diff(r_first, ent_first) <= i_radius) &&
                   (cpmt_pkg::abs_diff(r_second, ent_second) <= i_radius);

    // Merged entry value for the configured mode.
    always_comb begin
        case (i_merge_mode)
            cpmt_pkg::MODE_MAX: begin
                mrg_first  = cpmt_pkg::max_v(ent_first, r_first);
                mrg_second = cpmt_pkg::max_v(ent_second, r_second);
            end
            cpmt_pkg::MODE_MIN: begin
                mrg_first  = cpmt_pkg::min_v(ent_first, r_first);
                mrg_second = cpmt_pkg::min_v(ent_second, r_second);
            end
            cpmt_pkg::MODE_REPLACE: begin
                mrg_first  = r_first;
                mrg_second = r_second;
            end
            default: begin
                mrg_first  = cpmt_pkg::min_v(ent_first, r_first);
                mrg_second = cpmt_pkg::max_v(ent_second, r_second);
            end
        endcase
    end

    // Memory read address: the requested entry on load, else the next scan entry.
    always_comb begin
        case (i_op)
            cpmt_pkg::OP_LOAD:       rd_addr = IW'(i_entry_index);
            cpmt_pkg::OP_SCAN_START: rd_addr = '0;
            cpmt_pkg::OP_SCAN:       rd_addr = r_scan_idx + IW'(1);
            default:                 rd_addr = r_scan_idx;
        endcase
    end

    // Memory write: merge back during the scan, or append at the end.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_scan_idx;
        wr_data = {mrg_second, mrg_first};
        if (i_op == cpmt_pkg::OP_SCAN) begin
            wr_en = match;
        end else if (i_op == cpmt_pkg::OP_FINISH) begin
            wr_en   = !r_matched && has_room;
            wr_addr = r_count[IW-1:0];
            wr_data = {r_second, r_first};
        end
    end

    // Table memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Request fields and result payload.
    always_ff @(posedge i_clk) begin
        case (i_op)
            cpmt_pkg::OP_LOAD: begin
                r_first       <= i_first_value;
                r_second      <= i_second_value;
                r_index       <= i_entry_index;
                r_read_first  <= '0;
                r_read_second <= '0;
                r_status      <= cpmt_pkg::ST_CLEARED;
            end
            cpmt_pkg::OP_READ_RESULT: begin
                r_status <= cpmt_pkg::ST_READ;
                if (read_hit) begin
                    r_read_first  <= ent_first;
                    r_read_second <= ent_second;
                end
            end
            cpmt_pkg::OP_REJECT: begin
                r_status <= cpmt_pkg::ST_REJECTED;
            end
            cpmt_pkg::OP_FINISH: begin
                if (r_matched) begin
                    r_status <= cpmt_pkg::ST_MERGED;
                end else if (has_room) begin
                    r_status <= cpmt_pkg::ST_APPENDED;
                end else begin
                    r_status <= cpmt_pkg::ST_FULL;
                end
            end
            default: begin
            end
        endcase
    end

    // Entry count, scan position and match flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_idx <= '0;
            r_matched  <= 1'b0;
        end else begin
            case (i_op)
                cpmt_pkg::OP_LOAD: begin
                    r_matched <= 1'b0;
                    if (i_command == cpmt_pkg::CMD_CLEAR) begin
                        r_count <= '0;
                    end
                end
                cpmt_pkg::OP_SCAN_START: begin
                    r_scan_idx <= '0;
                end
                cpmt_pkg::OP_SCAN: begin
                    r_scan_idx <= r_scan_idx + IW'(1);
                    if (match) begin
                        r_matched <= 1'b1;
                    end
                end
                cpmt_pkg::OP_FINISH: begin
                    if (!r_matched && has_room) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Status toward the controller.
    assign o_stat.in_cmd      = i_command;
    assign o_stat.sep_reject  = (cpmt_pkg::abs_diff(r_first, r_second) <= i_min_sep);
    assign o_stat.table_empty = (r_count == '0);
    assign o_stat.scan_last   = ((CW'(r_scan_idx) + CW'(1)) == r_count);

    assign o_result.status = r_status;
    assign o_result.count  = cpmt_pkg::COUNT_W'(r_count);
    assign o_result.first  = r_read_first;
    assign o_result.second = r_read_second;

endmodule

@@ hdl/coordinate_pair_merge_table.sv @@
// Top level of the coordinate pair merge table: register port, output register, core.
//
// The block holds up to TABLE_DEPTH coordinate pairs in a table memory with one
// registered read port. It answers one request at a time with one result, and gives
// nothing for the unused command code. A clear goes from acceptance straight to the
// result state, a read through the read state and a rejected insert through the check
// state. Any other insert passes the check state, then, unless the table is empty, the
// scan state, in which the read port visits each valid entry once, one entry per cycle,
// and merges it back in place when it matches, and then the finish state. The result
// state loads the result into the output register once that register is free. The
// next request can be accepted in the cycle after the result is loaded. A result
// waiting at the output does not stop the next request from being accepted. Reset and
// clear empty the table by zeroing the entry count; there is no clearing pass.
// Configuration registers lie at byte addresses 0 (merge mode), 4 (minimum separation)
// and 8 (match radius).
module coordinate_pair_merge_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] command, [13:2] first_value, [25:14] second_value, [31:26] entry_index
    input  logic [31:0] i_s_tdata,
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] status, [9:3] entry_count, [21:10] read_first, [33:22] read_second,
    // [39:34] zero
    output logic [39:0] o_m_tdata,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW = cpmt_pkg::VALUE_W;

    cpmt_pkg::t_merge_mode r_merge_mode;
    logic [VW-1:0]         r_min_sep;
    logic [VW-1:0]         r_radius;

    logic [cpmt_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    cpmt_pkg::t_result  r_out;
    logic               r_out_valid;
    cpmt_pkg::t_result  dp_result;
    cpmt_pkg::t_dp_stat dp_stat;
    cpmt_pkg::t_dp_op   dp_op;
    logic               out_free;
    logic               out_load;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_mode <= cpmt_pkg::MODE_MAX;
            r_min_sep    <= '0;
            r_radius     <= cpmt_pkg::RADIUS_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                cpmt_pkg::REG_MERGE_MODE: r_merge_mode <= cpmt_pkg::t_merge_mode'(pwdata[1:0]);
                cpmt_pkg::REG_MIN_SEP:    r_min_sep    <= pwdata[VW-1:0];
                cpmt_pkg::REG_RADIUS:     r_radius     <= pwdata[VW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            cpmt_pkg::REG_MERGE_MODE: prdata = {30'd0, r_merge_mode};
            cpmt_pkg::REG_MIN_SEP:    prdata = {{(32-VW){1'b0}}, r_min_sep};
            cpmt_pkg::REG_RADIUS:     prdata = {{(32-VW){1'b0}}, r_radius};
            default:                  prdata = '0;
        endcase
    end

    // Output register: loaded by the controller, emptied when the sink takes it.
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= dp_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.second, r_out.first, r_out.count, r_out.status};

    cpmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_out_free (out_free),
        .o_out_load (out_load),
        .i_stat     (dp_stat),
        .o_op       (dp_op)
    );

    cpmt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (dp_op),
        .o_stat         (dp_stat),
        .i_command      (cpmt_pkg::t_command'(i_s_tdata[1:0])),
        .i_first_value  (i_s_tdata[13:2]),
        .i_second_value (i_s_tdata[25:14]),
        .i_entry_index  (i_s_tdata[31:26]),
        .i_merge_mode   (r_merge_mode),
        .i_min_sep      (r_min_sep),
        .i_radius       (r_radius),
        .o_result       (dp_result)
    );

endmodule
